### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside reset
`define VPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check prop on every rising clock edge, reset included
`define VPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, constants and helpers shared by the partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

   localparam int SEGS      = 16;
   localparam int IDX_W     = $clog2(SEGS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ADDR_W    = 16;
   localparam int NUM_W     = 16;
   localparam int CSR_IDX_W = 8;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;
   localparam logic [1:0] POL_WORST = 2'd3;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SIZE = CSR_IDX_W'(1);

   localparam logic [1:0]        RESET_POLICY = POL_FIRST;
   localparam logic [ADDR_W-1:0] RESET_TOTAL  = {ADDR_W{1'b1}};

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic [NUM_W-1:0]  number;
   } tbl_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic [NUM_W-1:0]  number;
   } tbl_rd_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ASCAN  = 7'b0000010,
      S_AWRITE = 7'b0000100,
      S_RSCAN1 = 7'b0001000,
      S_RSCAN2 = 7'b0010000,
      S_RSHIFT = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
   endfunction

endpackage

### sv/vpa_table.sv
// ----------------------------------------------------------------------------
// vpa_table
// Free segment table: one write port, one combinational read port.
// ----------------------------------------------------------------------------
module vpa_table (
   input  logic                      clock,
   input  vpa_pkg::tbl_wr_type       tbl_wr,
   input  logic [vpa_pkg::IDX_W-1:0] rd_idx,
   output vpa_pkg::tbl_rd_type       tbl_rd
);

   logic [vpa_pkg::ADDR_W-1:0] start_ff  [vpa_pkg::SEGS];
   logic [vpa_pkg::ADDR_W-1:0] size_ff   [vpa_pkg::SEGS];
   logic [vpa_pkg::NUM_W-1:0]  number_ff [vpa_pkg::SEGS];

   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         start_ff[tbl_wr.idx]  <= tbl_wr.start;
         size_ff[tbl_wr.idx]   <= tbl_wr.size;
         number_ff[tbl_wr.idx] <= tbl_wr.number;
      end
   end

   assign tbl_rd.start  = start_ff[rd_idx];
   assign tbl_rd.size   = size_ff[rd_idx];
   assign tbl_rd.number = number_ff[rd_idx];

endmodule

### sv/vpa_seq.sv
// ----------------------------------------------------------------------------
// vpa_seq
// Scan sequencer: walks the table one entry a cycle to allocate or release.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpa_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [15:0]                   req_req_size,
   input  logic [15:0]                   req_release_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [15:0]                   rsp_start_addr,
   output logic [15:0]                   rsp_segment_number,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata,
   output vpa_pkg::tbl_wr_type           tbl_wr,
   output logic [vpa_pkg::IDX_W-1:0]     tbl_rd_idx,
   input  vpa_pkg::tbl_rd_type           tbl_rd
);

   localparam int AW = vpa_pkg::ADDR_W;
   localparam int IW = vpa_pkg::IDX_W;
   localparam int CW = vpa_pkg::CNT_W;
   localparam int NW = vpa_pkg::NUM_W;

   vpa_pkg::state_type state_ff, state_in;
   logic [1:0]    policy_ff, policy_in;
   logic [AW-1:0] total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [NW-1:0] last_ff, last_in;
   logic [AW-1:0] size_ff, size_in;
   logic [AW-1:0] rs_ff, rs_in;
   logic [AW:0]   rel_end_ff, rel_end_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff, n_in;
   logic          found_ff, found_in;
   logic [IW-1:0] m_idx_ff, m_idx_in;
   logic [AW-1:0] m_start_ff, m_start_in;
   logic [AW-1:0] m_size_ff, m_size_in;
   logic [NW-1:0] m_num_ff, m_num_in;
   logic          res_ok_ff, res_ok_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [NW-1:0] res_num_ff, res_num_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [NW-1:0] rsp_num_ff, rsp_num_in;

   logic [AW:0]   e_end;
   logic [AW:0]   m_end;
   logic          fits;
   logic [IW-1:0] idx_nx;
   logic          req_acc;
   logic          csr_acc;
   logic [AW-1:0] merged;

   assign req_ready = (state_ff == vpa_pkg::S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == vpa_pkg::S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;

   assign e_end  = {1'b0, tbl_rd.start} + {1'b0, tbl_rd.size};
   assign m_end  = {1'b0, m_start_ff} + {1'b0, m_size_ff};
   assign fits   = (tbl_rd.size >= size_ff);
   assign idx_nx = ((CW'(idx_ff) + CW'(1)) == count_ff) ? '0 : idx_ff + IW'(1);

   always_comb begin
      unique case (state_ff)
         vpa_pkg::S_ASCAN:  tbl_rd_idx = idx_ff;
         vpa_pkg::S_RSHIFT: tbl_rd_idx = n_ff[IW-1:0] + IW'(1);
         default:           tbl_rd_idx = n_ff[IW-1:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      size_in      = size_ff;
      rs_in        = rs_ff;
      rel_end_in   = rel_end_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      found_in     = found_ff;
      m_idx_in     = m_idx_ff;
      m_start_in   = m_start_ff;
      m_size_in    = m_size_ff;
      m_num_in     = m_num_ff;
      res_ok_in    = res_ok_ff;
      res_addr_in  = res_addr_ff;
      res_num_in   = res_num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_num_in   = rsp_num_ff;
      tbl_wr       = '0;
      merged       = '0;

      unique case (state_ff)
         vpa_pkg::S_IDLE: begin
            if (csr_acc && (csr_index == vpa_pkg::CSR_FIT_POLICY ||
                            csr_index == vpa_pkg::CSR_TOTAL_SIZE)) begin
               if (csr_index == vpa_pkg::CSR_FIT_POLICY) begin
                  policy_in = csr_wdata[1:0];
               end else begin
                  total_in = csr_wdata;
               end
               tbl_wr.we     = 1'b1;
               tbl_wr.idx    = '0;
               tbl_wr.start  = '0;
               tbl_wr.size   = (csr_index == vpa_pkg::CSR_TOTAL_SIZE) ? csr_wdata : total_ff;
               tbl_wr.number = NW'(1);
               count_in      = CW'(1);
               ptr_in        = '0;
               last_in       = NW'(1);
            end else if (req_acc) begin
               size_in    = req_req_size;
               rs_in      = req_release_start;
               rel_end_in = {1'b0, req_release_start} + {1'b0, req_req_size};
               n_in       = '0;
               found_in   = 1'b0;
               res_ok_in   = 1'b0;
               res_addr_in = '0;
               res_num_in  = '0;
               if (req_opcode == vpa_pkg::OP_ALLOC) begin
                  idx_in   = (policy_ff == vpa_pkg::POL_NEXT && CW'(ptr_ff) < count_ff)
                             ? ptr_ff : '0;
                  state_in = vpa_pkg::S_ASCAN;
               end else begin
                  state_in = vpa_pkg::S_RSCAN1;
               end
            end
         end

         vpa_pkg::S_ASCAN: begin
            if (n_ff == count_ff) begin
               if (policy_ff == vpa_pkg::POL_NEXT) begin
                  ptr_in = idx_ff;
               end
               if (found_ff && (policy_ff != vpa_pkg::POL_WORST || m_size_ff >= size_ff)) begin
                  state_in = vpa_pkg::S_AWRITE;
               end else begin
                  state_in = vpa_pkg::S_FINISH;
               end
            end else begin
               idx_in = idx_nx;
               n_in   = n_ff + CW'(1);
               unique case (policy_ff)
                  vpa_pkg::POL_FIRST, vpa_pkg::POL_NEXT: begin
                     if (fits) begin
                        found_in = 1'b1;
                        state_in = vpa_pkg::S_AWRITE;
                        if (policy_ff == vpa_pkg::POL_NEXT) begin
                           ptr_in = idx_nx;
                        end
                     end
                  end
                  vpa_pkg::POL_BEST: begin
                     if (fits && (!found_ff || tbl_rd.size < m_size_ff)) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                     if (!found_ff || tbl_rd.size > m_size_ff) begin
                        found_in = 1'b1;
                     end
                  end
               endcase
               if (found_in && (state_in == vpa_pkg::S_AWRITE ||
                                policy_ff == vpa_pkg::POL_BEST ||
                                policy_ff == vpa_pkg::POL_WORST) &&
                   (!found_ff || policy_ff == vpa_pkg::POL_FIRST ||
                    policy_ff == vpa_pkg::POL_NEXT ||
                    (policy_ff == vpa_pkg::POL_BEST && fits && tbl_rd.size < m_size_ff) ||
                    (policy_ff == vpa_pkg::POL_WORST && tbl_rd.size > m_size_ff))) begin
                  m_idx_in   = idx_ff;
                  m_start_in = tbl_rd.start;
                  m_size_in  = tbl_rd.size;
                  m_num_in   = tbl_rd.number;
               end
            end
         end

         vpa_pkg::S_AWRITE: begin
            tbl_wr.we     = 1'b1;
            tbl_wr.idx    = m_idx_ff;
            tbl_wr.start  = m_start_ff + size_ff;
            tbl_wr.size   = m_size_ff - size_ff;
            tbl_wr.number = m_num_ff;
            res_ok_in     = 1'b1;
            res_addr_in   = m_start_ff;
            res_num_in    = m_num_ff;
            state_in      = vpa_pkg::S_FINISH;
         end

         vpa_pkg::S_RSCAN1: begin
            if (n_ff == count_ff) begin
               if (count_ff < CW'(vpa_pkg::SEGS)) begin
                  last_in       = last_ff + NW'(1);
                  tbl_wr.we     = 1'b1;
                  tbl_wr.idx    = count_ff[IW-1:0];
                  tbl_wr.start  = rs_ff;
                  tbl_wr.size   = size_ff;
                  tbl_wr.number = last_in;
                  count_in      = count_ff + CW'(1);
                  res_ok_in     = 1'b1;
               end
               state_in = vpa_pkg::S_FINISH;
            end else if (e_end == {1'b0, rs_ff} || rel_end_ff == {1'b0, tbl_rd.start}) begin
               merged        = vpa_pkg::sat_add(tbl_rd.size, size_ff);
               m_start_in    = (e_end == {1'b0, rs_ff}) ? tbl_rd.start : rs_ff;
               m_size_in     = merged;
               m_num_in      = tbl_rd.number;
               m_idx_in      = n_ff[IW-1:0];
               tbl_wr.we     = 1'b1;
               tbl_wr.idx    = n_ff[IW-1:0];
               tbl_wr.start  = m_start_in;
               tbl_wr.size   = merged;
               tbl_wr.number = tbl_rd.number;
               n_in          = '0;
               state_in      = vpa_pkg::S_RSCAN2;
            end else begin
               n_in = n_ff + CW'(1);
            end
         end

         vpa_pkg::S_RSCAN2: begin
            if (n_ff == count_ff) begin
               res_ok_in = 1'b1;
               state_in  = vpa_pkg::S_FINISH;
            end else if (n_ff[IW-1:0] != m_idx_ff &&
                         (m_end == {1'b0, tbl_rd.start} || e_end == {1'b0, m_start_ff})) begin
               merged        = vpa_pkg::sat_add(m_size_ff, tbl_rd.size);
               tbl_wr.we     = 1'b1;
               tbl_wr.idx    = m_idx_ff;
               tbl_wr.start  = (m_end == {1'b0, tbl_rd.start}) ? m_start_ff : tbl_rd.start;
               tbl_wr.size   = merged;
               tbl_wr.number = m_num_ff;
               state_in      = vpa_pkg::S_RSHIFT;
            end else begin
               n_in = n_ff + CW'(1);
            end
         end

         vpa_pkg::S_RSHIFT: begin
            if ((n_ff + CW'(1)) < count_ff) begin
               tbl_wr.we     = 1'b1;
               tbl_wr.idx    = n_ff[IW-1:0];
               tbl_wr.start  = tbl_rd.start;
               tbl_wr.size   = tbl_rd.size;
               tbl_wr.number = tbl_rd.number;
               n_in          = n_ff + CW'(1);
            end else begin
               count_in  = count_ff - CW'(1);
               res_ok_in = 1'b1;
               state_in  = vpa_pkg::S_FINISH;
            end
         end

         vpa_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_addr_in  = res_addr_ff;
               rsp_num_in   = res_num_ff;
               state_in     = vpa_pkg::S_IDLE;
            end
         end

         default: state_in = vpa_pkg::S_IDLE;
      endcase

      // hold entry 0 at the reset segment while in reset
      if (reset) begin
         tbl_wr.we     = 1'b1;
         tbl_wr.idx    = '0;
         tbl_wr.start  = '0;
         tbl_wr.size   = vpa_pkg::RESET_TOTAL;
         tbl_wr.number = NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpa_pkg::S_IDLE;
         policy_ff    <= vpa_pkg::RESET_POLICY;
         total_ff     <= vpa_pkg::RESET_TOTAL;
         count_ff     <= CW'(1);
         ptr_ff       <= '0;
         last_ff      <= NW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      rs_ff       <= rs_in;
      rel_end_ff  <= rel_end_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      found_ff    <= found_in;
      m_idx_ff    <= m_idx_in;
      m_start_ff  <= m_start_in;
      m_size_ff   <= m_size_in;
      m_num_ff    <= m_num_in;
      res_ok_ff   <= res_ok_in;
      res_addr_ff <= res_addr_in;
      res_num_ff  <= res_num_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_num_ff  <= rsp_num_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_start_addr     = rsp_addr_ff;
   assign rsp_segment_number = rsp_num_ff;

   `VPA_ASSERT(a_count_range, clock, reset,
      count_ff >= CW'(1) && count_ff <= CW'(vpa_pkg::SEGS), "segment count out of range")
   `VPA_ASSERT(a_busy_after_req, clock, reset,
      req_acc |=> state_ff != vpa_pkg::S_IDLE, "sequencer idle after request")
   `VPA_ASSERT(a_fail_zero, clock, reset,
      rsp_valid_ff && !rsp_ok_ff |-> rsp_addr_ff == '0 && rsp_num_ff == '0,
      "failed response carries data")
   `VPA_ASSERT(a_no_wr_finish, clock, reset,
      state_ff == vpa_pkg::S_FINISH |-> !tbl_wr.we, "table written while finishing")

endmodule

### sv/variable_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_top
// Free-list allocator with first, next, best and worst fit and coalescing.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the table scan visits one entry a cycle.
// Ready is low from request accept until the response is registered.
// Reset clears control state and rebuilds the table as one segment [0, 65535).
// A valid configuration write rebuilds the table with one write to entry 0; no clearing pass.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [15:0]                   req_req_size,
   input  logic [15:0]                   req_release_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [15:0]                   rsp_start_addr,
   output logic [15:0]                   rsp_segment_number,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);

   vpa_pkg::tbl_wr_type           tbl_wr;
   vpa_pkg::tbl_rd_type           tbl_rd;
   logic [vpa_pkg::IDX_W-1:0]     tbl_rd_idx;

   vpa_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_req_size       (req_req_size),
      .req_release_start  (req_release_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_start_addr     (rsp_start_addr),
      .rsp_segment_number (rsp_segment_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .tbl_wr             (tbl_wr),
      .tbl_rd_idx         (tbl_rd_idx),
      .tbl_rd             (tbl_rd)
   );

   vpa_table u_table (
      .clock  (clock),
      .tbl_wr (tbl_wr),
      .rd_idx (tbl_rd_idx),
      .tbl_rd (tbl_rd)
   );

endmodule

### test/variable_partition_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_top_tb
// Drives allocate and release requests under randomly chosen fit policies and several
// total sizes, predicts each response from a local copy of the free table,
// and compares responses field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top_tb;

   localparam int LIMIT = 20000;

   typedef struct {
      logic        op;
      logic [15:0] size;
      logic [15:0] rstart;
      logic        chk;
      logic        ok;
      logic [15:0] addr;
      logic [15:0] num;
   } row_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] addr;
      logic [15:0] num;
   } resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [15:0] req_req_size = '0;
   logic [15:0] req_release_start = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic [15:0] rsp_start_addr;
   logic [15:0] rsp_segment_number;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [vpa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]                   csr_wdata = '0;

   logic [1:0]  pol;
   logic [15:0] total;
   logic [15:0] fs_start [vpa_pkg::SEGS];
   logic [15:0] fs_size [vpa_pkg::SEGS];
   logic [15:0] fs_num [vpa_pkg::SEGS];
   int          fs_count;
   int          nf_ptr;
   logic [15:0] last_num;

   resp_type pending_resp [$];
   resp_type typed_resp [$];
   logic     typed_flag [$];
   int       errors = 0;
   int       idle_cycles = 0;
   logic     random_rsp = 1'b1;

   variable_partition_allocator_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void rebuild_table();
      for (int i = 0; i < vpa_pkg::SEGS; i++) begin
         fs_start[i] = '0;
         fs_size[i] = '0;
         fs_num[i] = '0;
      end
      fs_size[0] = total;
      fs_num[0] = 16'd1;
      fs_count = 1;
      nf_ptr = 0;
      last_num = 16'd1;
   endfunction

   function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hffff : s[15:0];
   endfunction

   function automatic void drop_seg(input int j);
      for (int k = j; k + 1 < fs_count; k++) begin
         fs_start[k] = fs_start[k+1];
         fs_size[k] = fs_size[k+1];
         fs_num[k] = fs_num[k+1];
      end
      fs_count--;
   endfunction

   function automatic resp_type predict_alloc(input logic [15:0] sz);
      resp_type r;
      int pick, p, idx;
      logic hit;
      r = '0;
      pick = 0;
      hit = 1'b0;
      case (pol)
         vpa_pkg::POL_FIRST: begin
            for (int i = 0; i < fs_count && !hit; i++)
               if (fs_size[i] >= sz) begin
                  pick = i;
                  hit = 1'b1;
               end
         end
         vpa_pkg::POL_NEXT: begin
            p = (nf_ptr < fs_count) ? nf_ptr : 0;
            for (int i = 0; i < fs_count; i++) begin
               idx = p;
               p = (p + 1) % fs_count;
               if (fs_size[idx] >= sz) begin
                  pick = idx;
                  hit = 1'b1;
                  break;
               end
            end
            nf_ptr = p;
         end
         vpa_pkg::POL_BEST: begin
            for (int i = 0; i < fs_count; i++)
               if (fs_size[i] >= sz && (!hit || fs_size[i] < fs_size[pick])) begin
                  pick = i;
                  hit = 1'b1;
               end
         end
         default: begin
            for (int i = 1; i < fs_count; i++)
               if (fs_size[i] > fs_size[pick]) pick = i;
            hit = fs_size[pick] >= sz;
         end
      endcase
      if (!hit) return r;
      r.ok = 1'b1;
      r.addr = fs_start[pick];
      r.num = fs_num[pick];
      fs_start[pick] = fs_start[pick] + sz;
      fs_size[pick] = fs_size[pick] - sz;
      return r;
   endfunction

   function automatic resp_type predict_release(input logic [15:0] rs, input logic [15:0] sz);
      resp_type r;
      int i;
      logic hit;
      r = '0;
      hit = 1'b0;
      for (i = 0; i < fs_count; i++) begin
         if ({1'b0, fs_start[i]} + fs_size[i] == {1'b0, rs}) begin
            fs_size[i] = sat16(fs_size[i], sz);
            hit = 1'b1;
            break;
         end
         if ({1'b0, rs} + sz == {1'b0, fs_start[i]}) begin
            fs_start[i] = rs;
            fs_size[i] = sat16(fs_size[i], sz);
            hit = 1'b1;
            break;
         end
      end
      if (hit) begin
         for (int j = 0; j < fs_count; j++) begin
            if (j == i) continue;
            if ({1'b0, fs_start[i]} + fs_size[i] == {1'b0, fs_start[j]}) begin
               fs_size[i] = sat16(fs_size[i], fs_size[j]);
               drop_seg(j);
               break;
            end
            if ({1'b0, fs_start[j]} + fs_size[j] == {1'b0, fs_start[i]}) begin
               fs_start[i] = fs_start[j];
               fs_size[i] = sat16(fs_size[i], fs_size[j]);
               drop_seg(j);
               break;
            end
         end
         r.ok = 1'b1;
         return r;
      end
      if (fs_count >= vpa_pkg::SEGS) return r;
      last_num = last_num + 16'd1;
      fs_start[fs_count] = rs;
      fs_size[fs_count] = sz;
      fs_num[fs_count] = last_num;
      fs_count++;
      r.ok = 1'b1;
      return r;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("error: %s got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic write_csr(input logic [vpa_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == vpa_pkg::CSR_FIT_POLICY) pol = val[1:0];
      else if (idx == vpa_pkg::CSR_TOTAL_SIZE) total = val;
      if (idx == vpa_pkg::CSR_FIT_POLICY || idx == vpa_pkg::CSR_TOTAL_SIZE) rebuild_table();
   endtask

   // leaves valid high after the accept; the caller drops it before waiting
   task automatic send(input row_type row);
      resp_type r;
      resp_type t;
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= row.op;
      req_req_size <= row.size;
      req_release_start <= row.rstart;
      do @(posedge clock); while (!req_ready);
      if (row.op == vpa_pkg::OP_ALLOC) r = predict_alloc(row.size);
      else r = predict_release(row.rstart, row.size);
      t = '{row.ok, row.addr, row.num};
      pending_resp.insert(pending_resp.size(), r);
      typed_flag.insert(typed_flag.size(), row.chk);
      typed_resp.insert(typed_resp.size(), t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_resp.size() != 0) @(posedge clock);
      repeat (3 * vpa_pkg::SEGS + 10) @(posedge clock);
   endtask

   // response side: random stalls, compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_resp.size() == 0) begin
               report("unexpected response", int'(rsp_ok), 0);
            end else begin
               resp_type e, t;
               logic f;
               e = pending_resp[0];
               pending_resp.delete(0);
               t = typed_resp[0];
               typed_resp.delete(0);
               f = typed_flag[0];
               typed_flag.delete(0);
               if (f && t != e) report("directed row vs predictor", int'(t), int'(e));
               if (rsp_ok !== e.ok) report("ok", int'(rsp_ok), int'(e.ok));
               if (rsp_start_addr !== e.addr)
                  report("start_addr", int'(rsp_start_addr), int'(e.addr));
               if (rsp_segment_number !== e.num)
                  report("segment_number", int'(rsp_segment_number), int'(e.num));
            end
         end
         rsp_ready <= random_rsp ? ($urandom_range(0, 99) < 70) : 1'b1;
      end
   end

   // watchdog: cycles with no accepted transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("variable_partition_allocator_top: mismatch");
         $finish;
      end
   end

   initial begin
      row_type dir [$];
      row_type row;
      logic [15:0] held_start [$];
      logic [15:0] held_size [$];
      int k;
      pol = vpa_pkg::RESET_POLICY;
      total = vpa_pkg::RESET_TOTAL;
      rebuild_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: after reset, extremes, policies, merges, full table
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'd0, 16'h0, 1, 1, 16'h0, 16'd1});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'd100, 16'hffff, 1, 1, 16'h0, 16'd1});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'hffff, 16'h0, 1, 0, 16'h0, 16'd0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_RELEASE, 16'd100, 16'h0, 1, 1, 16'h0, 16'd0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'hffff, 16'h0, 1, 1, 16'h0, 16'd1});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'd1, 16'h0, 1, 0, 16'h0, 16'd0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_RELEASE, 16'd10, 16'd100, 0, 0, 0, 0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_RELEASE, 16'd10, 16'd200, 0, 0, 0, 0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_RELEASE, 16'd90, 16'd110, 0, 0, 0, 0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_RELEASE, 16'hffff, 16'hfff0, 0, 0, 0, 0});
      dir.insert(dir.size(), row_type'{vpa_pkg::OP_ALLOC, 16'd5, 16'h0, 0, 0, 0, 0});
      for (int i = 0; i < 16; i++)
         dir.insert(dir.size(),
                    row_type'{vpa_pkg::OP_RELEASE, 16'd1, 16'(1000 + 4 * i), 0, 0, 0, 0});
      foreach (dir[i]) send(dir[i]);
      drain();

      write_csr(vpa_pkg::CSR_FIT_POLICY, 16'(vpa_pkg::POL_WORST));
      write_csr(vpa_pkg::CSR_TOTAL_SIZE, 16'd1);
      send('{vpa_pkg::OP_ALLOC, 16'd1, 16'h0, 1, 1, 16'h0, 16'd1});
      send('{vpa_pkg::OP_ALLOC, 16'd0, 16'h0, 1, 1, 16'h1, 16'd1});
      send('{vpa_pkg::OP_ALLOC, 16'd1, 16'h0, 1, 0, 16'h0, 16'd0});
      drain();
      write_csr(8'd2, 16'hffff);
      write_csr(8'hff, 16'h0);
      send('{vpa_pkg::OP_ALLOC, 16'd0, 16'h0, 1, 1, 16'h1, 16'd1});
      drain();

      // random phases: mostly alloc/free cycles of real blocks, some noise
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(vpa_pkg::CSR_FIT_POLICY,
                   16'($urandom_range(0, 3)) | 16'($urandom) & 16'hfffc);
         case (ph)
            0: write_csr(vpa_pkg::CSR_TOTAL_SIZE, 16'hffff);
            1: write_csr(vpa_pkg::CSR_TOTAL_SIZE, 16'd1);
            default: write_csr(vpa_pkg::CSR_TOTAL_SIZE, 16'($urandom_range(16, 4096)));
         endcase
         held_start.delete();
         held_size.delete();
         random_rsp = (ph != 3);
         for (int n = 0; n < 85; n++) begin
            row.chk = 0;
            row.ok = 0;
            row.addr = 0;
            row.num = 0;
            k = $urandom_range(0, 99);
            if (k < 45 || held_start.size() == 0) begin
               row.op = vpa_pkg::OP_ALLOC;
               row.size = (k < 3) ? 16'($urandom) : 16'($urandom_range(0, total / 6 + 1));
               row.rstart = 16'($urandom);
            end else if (k < 88) begin
               k = $urandom_range(0, held_start.size() - 1);
               row.op = vpa_pkg::OP_RELEASE;
               row.rstart = held_start[k];
               row.size = held_size[k];
               held_start.delete(k);
               held_size.delete(k);
            end else begin
               row.op = vpa_pkg::OP_RELEASE;
               row.rstart = 16'($urandom);
               row.size = 16'($urandom);
            end
            send(row);
            if (row.op == vpa_pkg::OP_ALLOC && pending_resp[$].ok && row.size != 0) begin
               held_start.insert(held_start.size(), pending_resp[$].addr);
               held_size.insert(held_size.size(), row.size);
            end
            if (n == 40) begin
               req_valid <= 1'b0;
               while (pending_resp.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0)
         $display("variable_partition_allocator_top: match");
      else
         $display("variable_partition_allocator_top: mismatch");
      $finish;
   end

endmodule
